// File: hdl/xild_pkg.sv
// shared types, constants and opcode tables for the instruction length decoder
// no dependencies
`default_nettype none
package xild_pkg;

    localparam int unsigned MaxLength   = 15;
    localparam int unsigned PrefixSlots = 15;
    localparam int unsigned QDepth      = 2;

    typedef enum logic [3:0] {
        PH_START, PH_AFTER_REX, PH_V5_1, PH_V4_1, PH_V4_2, PH_VOP, PH_ESC,
        PH_ESC38, PH_ESC3A, PH_MODRM, PH_SIB, PH_TAIL
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_INVALID = 2'd1, ST_TRUNC = 2'd2, ST_OVERLEN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MAP_NONE = 2'd0, MAP_PRIM = 2'd1, MAP_0F = 2'd2, MAP_0F3X = 2'd3
    } t_map;

    // outcome of one decode step
    typedef enum logic [1:0] {
        STEP_MORE = 2'd0, STEP_DONE = 2'd1, STEP_INVALID = 2'd2
    } t_step;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] length;
        logic [1:0] map_kind;
        logic [7:0] opcode;
        logic       modrm_valid;
        logic [7:0] modrm;
        logic       sib_valid;
        logic [7:0] sib;
        logic [2:0] disp_len;
        logic [3:0] imm_len;
        logic [3:0] prefix_count;
        logic [7:0] rex;
    } t_out;

    // primary map flags
    localparam logic [7:0] F_MR = 8'h01, F_B1 = 8'h02, F_W2 = 8'h04, F_D4 = 8'h08,
                           F_OV = 8'h10, F_OQ = 8'h20, F_MO = 8'h40, F_BAD = 8'h80;

    function automatic logic [7:0] prim_flags(input logic [7:0] b);
        logic [7:0] f;
        f = 8'h00;
        if (b < 8'h40) begin
            if (b[2:0] < 3'd4) f = F_MR;
            else if (b[2:0] == 3'd4) f = F_B1;
            else if (b[2:0] == 3'd5) f = F_OV;
            else if (b[2:0] == 3'd7) f = F_BAD;
            else f = (b < 8'h20) ? F_BAD : 8'h00;
        end else if (b[7:4] == 4'h4) begin
            f = F_BAD;
        end else if (b[7:4] == 4'h7) begin
            f = F_B1;
        end else if (b[7:4] == 4'hB) begin
            f = b[3] ? F_OQ : F_B1;
        end else if (b[7:4] == 4'hE) begin
            if (!b[3]) f = F_B1;
            else if (b[2:1] == 2'b00) f = F_D4;
            else if (b[2:0] == 3'd2) f = F_BAD;
            else if (b[2:0] == 3'd3) f = F_B1;
        end else begin
            unique case (b)
                8'h60, 8'h61, 8'h62, 8'h82, 8'h9A, 8'hC4, 8'hC5, 8'hCE,
                8'hD4, 8'hD5, 8'hD6, 8'hEA, 8'hF0, 8'hF2, 8'hF3: f = F_BAD;
                8'h63, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B,
                8'h8C, 8'h8D, 8'h8E, 8'h8F, 8'hD0, 8'hD1, 8'hD2, 8'hD3,
                8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE, 8'hDF,
                8'hF6, 8'hF7, 8'hFE, 8'hFF: f = F_MR;
                8'h68, 8'hA9: f = F_OV;
                8'h69, 8'h81, 8'hC7: f = F_MR | F_OV;
                8'h6A, 8'hA8, 8'hCD: f = F_B1;
                8'h6B, 8'h80, 8'h83, 8'hC0, 8'hC1, 8'hC6: f = F_MR | F_B1;
                8'hA0, 8'hA1, 8'hA2, 8'hA3: f = F_MO;
                8'hC2, 8'hCA: f = F_W2;
                default: f = 8'h00;
            endcase
        end
        return f;
    endfunction

    function automatic logic is_legacy_prefix(input logic [7:0] b);
        return (b == 8'hF0) || (b == 8'hF2) || (b == 8'hF3) || (b == 8'h2E) ||
               (b == 8'h36) || (b == 8'h3E) || (b == 8'h26) || (b == 8'h64) ||
               (b == 8'h65) || (b == 8'h67) || (b == 8'h66);
    endfunction

endpackage
`default_nettype wire

// File: hdl/xild_if.sv
// valid/ready channel interface carrying one payload struct
// depends on xild_pkg
`default_nettype none
interface xild_in_if;
    xild_pkg::t_in payload;
    logic          valid;
    logic          ready;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface xild_out_if;
    xild_pkg::t_out payload;
    logic           valid;
    logic           ready;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hdl/xild_front.sv
// front: byte classifier and decode state machine, one byte per cycle while i_space is high
// depends on xild_pkg and xild_if
`default_nettype none
module xild_front (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    xild_in_if.sink        i_in,
    input  wire logic      i_space,
    output xild_pkg::t_out o_res,
    output logic           o_res_valid
);
    import xild_pkg::*;

    t_phase     r_phase, n_phase;
    logic [4:0] r_cnt, n_cnt;
    logic [3:0] r_pfx, n_pfx;
    logic       r_osz, n_osz, r_w, n_w, r_mrn, n_mrn;
    logic [7:0] r_rex, n_rex, r_vex, n_vex, r_op, n_op, r_mrm, n_mrm;
    logic [1:0] r_map, n_map;
    logic [8:0] r_sib, n_sib;
    logic [2:0] r_disp, n_disp;
    logic [3:0] r_imm, n_imm, r_left, n_left;

    logic [7:0] b;
    logic       last, take;
    t_step      r;
    logic [7:0] pf;
    logic [7:0] m5;

    assign b    = i_in.payload.data_byte;
    assign last = i_in.payload.buffer_end;
    assign i_in.ready = i_space;
    assign take = i_in.valid && i_space;
    assign pf   = prim_flags(b);
    assign m5   = {3'd0, r_vex[4:0]};

    always_comb begin
        logic        opstart, do_two, do_prim, after_op, tail;
        logic [3:0]  prim_imm;
        n_phase = r_phase; n_pfx = r_pfx; n_osz = r_osz; n_w = r_w; n_rex = r_rex;
        n_vex = r_vex; n_map = r_map; n_op = r_op; n_mrn = r_mrn; n_mrm = r_mrm;
        n_sib = r_sib; n_disp = r_disp; n_imm = r_imm; n_left = r_left;
        n_cnt = (r_cnt < 5'd31) ? r_cnt + 5'd1 : r_cnt;
        r = STEP_MORE;
        opstart = 1'b0; do_two = 1'b0; do_prim = 1'b0; after_op = 1'b0; tail = 1'b0;
        prim_imm = 4'd0;
        unique case (r_phase)
            PH_AFTER_REX: opstart = 1'b1;
            PH_V5_1: begin
                n_vex = 8'h01; n_phase = PH_VOP;
            end
            PH_V4_1: begin
                if (last) begin
                    n_map = MAP_PRIM; n_op = 8'hC4; r = STEP_INVALID;
                end else begin
                    n_vex = b; n_phase = PH_V4_2;
                end
            end
            PH_V4_2: begin
                n_w = b[7]; n_phase = PH_VOP;
            end
            PH_VOP: begin
                n_op = b;
                if (m5 == 8'd1) begin
                    n_map = MAP_0F; do_two = 1'b1;
                end else if (m5 == 8'd2 || m5 == 8'd3) begin
                    n_map = MAP_0F3X; n_mrn = 1'b1;
                    n_imm = (m5 == 8'd3) ? 4'd1 : 4'd0; after_op = 1'b1;
                end else begin
                    r = STEP_INVALID;
                end
            end
            PH_ESC: begin
                if (b == 8'h38) n_phase = PH_ESC38;
                else if (b == 8'h3A) n_phase = PH_ESC3A;
                else begin
                    n_map = MAP_0F; n_op = b; do_two = 1'b1;
                end
            end
            PH_ESC38, PH_ESC3A: begin
                n_map = MAP_0F3X; n_op = b; n_mrn = 1'b1;
                n_imm = (r_phase == PH_ESC3A) ? 4'd1 : 4'd0; after_op = 1'b1;
            end
            PH_MODRM: begin
                n_mrm = b;
                if (r_map == MAP_PRIM && (r_op == 8'hF6 || r_op == 8'hF7) && b[5:4] == 2'd0)
                    n_imm = (r_op == 8'hF6) ? 4'd1 : (r_osz ? 4'd2 : 4'd4);
                if (b[7:6] == 2'd3) begin
                    n_disp = 3'd0; tail = 1'b1;
                end else if (b[2:0] == 3'd4) begin
                    n_phase = PH_SIB;
                end else begin
                    if (b[7:6] == 2'd0) n_disp = (b[2:0] == 3'd5) ? 3'd4 : 3'd0;
                    else n_disp = (b[7:6] == 2'd1) ? 3'd1 : 3'd4;
                    tail = 1'b1;
                end
            end
            PH_SIB: begin
                n_sib = {1'b1, b};
                if (r_mrm[7:6] == 2'd0) n_disp = (b[2:0] == 3'd5) ? 3'd4 : 3'd0;
                else n_disp = (r_mrm[7:6] == 2'd1) ? 3'd1 : 3'd4;
                tail = 1'b1;
            end
            PH_TAIL: begin
                if (r_left != 4'd0) n_left = r_left - 4'd1;
                r = (n_left == 4'd0) ? STEP_DONE : STEP_MORE;
            end
            default: begin
                if (r_pfx < 4'(PrefixSlots) && is_legacy_prefix(b)) begin
                    n_pfx = r_pfx + 4'd1;
                    if (b == 8'h66) n_osz = 1'b1;
                end else if (b[7:4] == 4'h4) begin
                    n_rex = b; n_w = b[3]; n_phase = PH_AFTER_REX;
                end else begin
                    opstart = 1'b1;
                end
            end
        endcase
        if (opstart) begin
            if (b == 8'hC5 || b == 8'hC4) begin
                if (last) begin
                    n_map = MAP_PRIM; n_op = b; r = STEP_INVALID;
                end else begin
                    n_phase = (b == 8'hC5) ? PH_V5_1 : PH_V4_1;
                end
            end else if (b == 8'h0F) begin
                n_phase = PH_ESC;
            end else begin
                do_prim = 1'b1;
            end
        end
        if (do_prim) begin
            n_map = MAP_PRIM; n_op = b;
            if (pf[7]) r = STEP_INVALID;
            else begin
                n_mrn = pf[0];
                if (pf[1]) prim_imm = 4'd1;
                else if (pf[2]) prim_imm = 4'd2;
                else if (pf[3]) prim_imm = 4'd4;
                else if (pf[4]) prim_imm = r_osz ? 4'd2 : 4'd4;
                else if (pf[5]) prim_imm = r_w ? 4'd8 : (r_osz ? 4'd2 : 4'd4);
                else if (pf[6]) prim_imm = 4'd8;
                if (b == 8'hC8) prim_imm = 4'd3;
                n_imm = prim_imm; after_op = 1'b1;
            end
        end
        if (do_two) begin
            n_mrn = 1'b1; n_imm = 4'd0;
            unique case (b)
                8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0B, 8'h30, 8'h31, 8'h32, 8'h33,
                8'h34, 8'h35, 8'h37, 8'hA0, 8'hA1, 8'hA2, 8'hA8, 8'hA9, 8'hAA,
                8'hC8, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE, 8'hCF: n_mrn = 1'b0;
                8'h70, 8'h71, 8'h72, 8'h73, 8'hA4, 8'hAC, 8'hBA,
                8'hC2, 8'hC4, 8'hC5, 8'hC6: n_imm = 4'd1;
                default: begin
                    if (b[7:4] == 4'h8) begin
                        n_mrn = 1'b0; n_imm = 4'd4;
                    end
                end
            endcase
            after_op = 1'b1;
        end
        if (after_op) begin
            if (n_mrn) n_phase = PH_MODRM;
            else begin
                n_disp = 3'd0; tail = 1'b1;
            end
        end
        if (tail) begin
            n_left = 4'({1'b0, n_disp} + n_imm);
            if (n_left == 4'd0) r = STEP_DONE;
            else n_phase = PH_TAIL;
        end
    end

    always_comb begin
        o_res_valid = take && (r != STEP_MORE || last);
        o_res.status = (r == STEP_MORE) ? ST_TRUNC : (r == STEP_INVALID) ? ST_INVALID :
                       (n_cnt > 5'(MaxLength)) ? ST_OVERLEN : ST_OK;
        o_res.length = n_cnt;       o_res.map_kind = n_map;
        o_res.opcode = n_op;        o_res.modrm_valid = n_mrn;
        o_res.modrm = n_mrm;        o_res.sib_valid = n_sib[8];
        o_res.sib = n_sib[7:0];     o_res.disp_len = n_disp;
        o_res.imm_len = n_imm;      o_res.prefix_count = n_pfx;
        o_res.rex = n_rex;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (take && o_res_valid)) begin
            r_phase <= PH_START; r_cnt <= '0; r_pfx <= '0; r_osz <= 1'b0; r_w <= 1'b0;
            r_rex <= '0; r_vex <= '0; r_map <= '0; r_op <= '0; r_mrn <= 1'b0;
            r_mrm <= '0; r_sib <= '0; r_disp <= '0; r_imm <= '0; r_left <= '0;
        end else if (take) begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_pfx <= n_pfx; r_osz <= n_osz;
            r_w <= n_w; r_rex <= n_rex; r_vex <= n_vex; r_map <= n_map; r_op <= n_op;
            r_mrn <= n_mrn; r_mrm <= n_mrm; r_sib <= n_sib; r_disp <= n_disp;
            r_imm <= n_imm; r_left <= n_left;
        end
    end

    a_tail_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_TAIL |-> r_left != 4'd0) else $error("tail with nothing left");
    a_sib_after_modrm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SIB |-> r_mrm[2:0] == 3'd4 && r_mrm[7:6] != 2'd3)
        else $error("sib phase without sib modrm");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> $stable(r_phase) && $stable(r_cnt)) else $error("state moved on stall");
endmodule
`default_nettype wire

// File: hdl/xild_queue.sv
// result queue between decode front and the o_out channel
// depends on xild_pkg
`default_nettype none
module xild_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_wr,
    input  xild_pkg::t_out i_data,
    output logic           o_space,
    output logic           o_nonempty,
    output xild_pkg::t_out o_data,
    input  wire logic      i_rd
);
    import xild_pkg::*;

    t_out       r_mem [QDepth];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_space    = r_cnt != 2'(QDepth);
    assign o_nonempty = r_cnt != 2'd0;
    assign o_data     = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp ^ i_wr;
        n_rp  = r_rp ^ i_rd;
        n_cnt = r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            r_wp <= n_wp; r_rp <= n_rp; r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'(QDepth) |-> !i_wr) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd0 |-> !i_rd) else $error("queue underflow");
    a_count_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) == (r_wp != r_rp)) else $error("count and pointers disagree");
endmodule
`default_nettype wire

// File: hdl/x86_64_instruction_length_decoder.sv
// channel   dir  payload
// i_in      in   data_byte, buffer_end
// o_out     out  status, length, map_kind, opcode, modrm, sib, sizes, prefix_count, rex
// one byte per cycle while the queue has space; a result leaves the decode state
// in the cycle its last byte is taken and passes through a two-entry result queue
// reset is synchronous; the queue is empty and decode waits for a prefix or opcode after it
// the input stalls only when the queue is full, set by the output side's ready
`default_nettype none
module x86_64_instruction_length_decoder (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    xild_in_if.sink   i_in,
    xild_out_if.source o_out
);
    import xild_pkg::*;

    t_out res;
    logic res_valid, space, nonempty;

    xild_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_space(space),
        .o_res(res), .o_res_valid(res_valid)
    );

    xild_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(res_valid), .i_data(res),
        .o_space(space), .o_nonempty(nonempty), .o_data(o_out.payload),
        .i_rd(nonempty && o_out.ready)
    );

    assign o_out.valid = nonempty;
endmodule
`default_nettype wire
